// File: rtl/sjf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared widths, constants and types of the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

	localparam int VAL_W        = 16;
	localparam int TIME_W       = 22;
	localparam int IDX_W        = 6;
	localparam int MAX_JOBS_DEF = 32;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// one stored job
	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] burst;
		logic [VAL_W-1:0] arrival;
	} job_t;

	// scan word into the pick unit
	typedef struct packed {
		logic             clear;
		logic             valid;
		logic [IDX_W-1:0] idx;
	} scan_ctl_t;

	// chosen job
	typedef struct packed {
		logic             valid;
		logic             arrived;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] burst;
		logic [VAL_W-1:0] arrival;
	} cand_t;

endpackage
`default_nettype wire

// File: rtl/sjf_nonpreemptive_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler
// Non-preemptive shortest-job-first scheduler over a loaded job set.
// ----------------------------------------------------------------------------
// Input words carry arrival_time and burst_length; last_in closes the set.
// Loading takes one word per cycle; up to MAX_JOBS jobs are kept, later
// words are dropped and set overflowed on every result of the set.
// After the last word the block schedules from time zero and sends one
// output word per job in run order: job_index, start_time, wait_time,
// turnaround_time, overflowed, last_out (on the final job).
// Each decision scans the job store through its single read port. in_ready
// is high only while loading; the last result may still wait in the output
// register while the next set loads.
// A stalled receiver holds the output register and the scheduler waits.
// Reset empties the set and clears the output register; the store needs
// no clearing pass.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_scheduler #(
	parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [sjf_pkg::VAL_W-1:0]   arrival_time,
	input  wire logic [sjf_pkg::VAL_W-1:0]   burst_length,
	input  wire logic                        last_in,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [sjf_pkg::IDX_W-1:0]        job_index,
	output logic [sjf_pkg::TIME_W-1:0]       start_time,
	output logic [sjf_pkg::TIME_W-1:0]       wait_time,
	output logic [sjf_pkg::TIME_W-1:0]       turnaround_time,
	output logic                             overflowed,
	output logic                             last_out
);
	import sjf_pkg::*;

	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);

	typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_EMIT} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q, rd_idx_q, k_q;
	logic [TIME_W-1:0]   clock_q;
	logic                drop_q;
	logic                rd_v_s1;
	logic [AW-1:0]       rd_addr_s1;
	logic                out_valid_q;

	logic                in_acc, room, issue, emit_go, last_job;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	job_t                mem_wdata, mem_rdata;
	scan_ctl_t           ctl;
	cand_t               pick;

	logic [TIME_W-1:0]   arr_ext, start_c, wait_c, tat_c, end_c;
	logic [TIME_W:0]     tat_sum, end_sum;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign room      = count_q < CW'(MAX_JOBS);
	assign issue     = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign last_job  = (k_q + CW'(1)) == count_q;

	always_comb begin
		arr_ext = {{(TIME_W-VAL_W){1'b0}}, pick.arrival};
		start_c = pick.arrived ? clock_q : arr_ext;
		wait_c  = start_c - arr_ext;
		tat_sum = {1'b0, wait_c} + {{(TIME_W+1-VAL_W){1'b0}}, pick.burst};
		end_sum = {1'b0, start_c} + {{(TIME_W+1-VAL_W){1'b0}}, pick.burst};
		tat_c   = tat_sum[TIME_W] ? TIME_MAX : tat_sum[TIME_W-1:0];
		end_c   = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
	end

	always_comb begin
		mem_we    = (in_acc && room) || emit_go;
		mem_waddr = (state_q == ST_LOAD) ? count_q[AW-1:0] : pick.idx[AW-1:0];
		if (state_q == ST_LOAD) begin
			mem_wdata.done    = 1'b0;
			mem_wdata.burst   = burst_length;
			mem_wdata.arrival = arrival_time;
		end else begin
			mem_wdata.done    = 1'b1;
			mem_wdata.burst   = pick.burst;
			mem_wdata.arrival = pick.arrival;
		end
		ctl.clear = (in_acc && last_in) || (emit_go && !last_job);
		ctl.valid = rd_v_s1;
		ctl.idx   = IDX_W'(rd_addr_s1);
	end

	sjf_mem #(
		.DEPTH(MAX_JOBS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (issue),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(mem_rdata)
	);

	sjf_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.entry     (mem_rdata),
		.clock_time(clock_q),
		.sel       (pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_addr_s1 <= rd_idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_LOAD;
			count_q         <= '0;
			rd_idx_q        <= '0;
			k_q             <= '0;
			clock_q         <= '0;
			drop_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			job_index       <= '0;
			start_time      <= '0;
			wait_time       <= '0;
			turnaround_time <= '0;
			overflowed      <= 1'b0;
			last_out        <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !emit_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							count_q <= count_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (last_in) begin
							state_q  <= ST_SCAN;
							rd_idx_q <= '0;
							k_q      <= '0;
							clock_q  <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end else if (!rd_v_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid_q     <= 1'b1;
						job_index       <= pick.idx;
						start_time      <= start_c;
						wait_time       <= wait_c;
						turnaround_time <= tat_c;
						overflowed      <= drop_q;
						last_out        <= last_job;
						if (last_job) begin
							state_q <= ST_LOAD;
							count_q <= '0;
							clock_q <= '0;
							drop_q  <= 1'b0;
							k_q     <= '0;
						end else begin
							state_q  <= ST_SCAN;
							clock_q  <= end_c;
							k_q      <= k_q + CW'(1);
							rd_idx_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_emit_has_pick: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> pick.valid)
		else $error("emit without a chosen job");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_JOBS))
		else $error("job count beyond capacity");

	a_last_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_in |=> state_q == ST_SCAN && !in_ready)
		else $error("last word did not start scheduling");

	a_scan_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> k_q < count_q)
		else $error("scan with no pending job");
`endif

endmodule
`default_nettype wire

// File: rtl/sjf_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjf_mem
// Job store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sjf_mem #(
	parameter int DEPTH = sjf_pkg::MAX_JOBS_DEF,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire sjf_pkg::job_t wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output sjf_pkg::job_t      rdata
);
	import sjf_pkg::*;

	job_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/sjf_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjf_pick
// Running selection over one scan of the job store. Tracks the best arrived
// job (shortest burst, then earliest arrival) and the earliest pending job
// (earliest arrival, then shortest burst) for the idle jump.
// ----------------------------------------------------------------------------
module sjf_pick (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sjf_pkg::scan_ctl_t        ctl,
	input  wire sjf_pkg::job_t             entry,
	input  wire logic [sjf_pkg::TIME_W-1:0] clock_time,
	output sjf_pkg::cand_t                 sel
);
	import sjf_pkg::*;

	logic             a_v_q, b_v_q;
	logic [IDX_W-1:0] a_idx_q, b_idx_q;
	logic [VAL_W-1:0] a_bur_q, b_bur_q, a_arr_q, b_arr_q;

	logic use_e, arrived, a_take, b_take;

	always_comb begin
		use_e   = ctl.valid && !entry.done;
		arrived = {{(TIME_W-VAL_W){1'b0}}, entry.arrival} <= clock_time;
		a_take  = use_e && arrived && (!a_v_q || entry.burst < a_bur_q ||
			(entry.burst == a_bur_q && entry.arrival < a_arr_q));
		b_take  = use_e && (!b_v_q || entry.arrival < b_arr_q ||
			(entry.arrival == b_arr_q && entry.burst < b_bur_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q <= 1'b0;
			b_v_q <= 1'b0;
		end else if (ctl.clear) begin
			a_v_q <= 1'b0;
			b_v_q <= 1'b0;
		end else begin
			if (a_take) a_v_q <= 1'b1;
			if (b_take) b_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (a_take) begin
			a_idx_q <= ctl.idx;
			a_bur_q <= entry.burst;
			a_arr_q <= entry.arrival;
		end
		if (b_take) begin
			b_idx_q <= ctl.idx;
			b_bur_q <= entry.burst;
			b_arr_q <= entry.arrival;
		end
	end

	always_comb begin
		sel.valid   = a_v_q || b_v_q;
		sel.arrived = a_v_q;
		sel.idx     = a_v_q ? a_idx_q : b_idx_q;
		sel.burst   = a_v_q ? a_bur_q : b_bur_q;
		sel.arrival = a_v_q ? a_arr_q : b_arr_q;
	end

endmodule
`default_nettype wire

// File: bench/tb_sjf_nonpreemptive_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sjf_nonpreemptive_scheduler
// Self-checking bench for the non-preemptive shortest-job-first scheduler.
// ----------------------------------------------------------------------------
// An initial block queues job sets. The first sets are hand-picked: extreme
// arrival and burst values, burst and arrival ties, idle jumps and zero-length
// jobs. After them come random sets, with some full and some overflowing sets
// among them. A clocked driver sends the queued words and predicts the run
// order of each set as its last word is taken. A clocked monitor checks every
// result word against the oldest prediction. Both sides idle in random bursts
// except near the end of the run.
// ----------------------------------------------------------------------------
module tb_sjf_nonpreemptive_scheduler;
	import sjf_pkg::*;

	localparam int JOB_SLOTS    = MAX_JOBS_DEF;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam int CALM_TAIL    = 50;
	localparam int FEED_TARGET  = 320;

	typedef struct {
		logic [VAL_W-1:0] arrival;
		logic [VAL_W-1:0] burst;
		logic             fin;
		logic             hold;
	} job_word_t;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] start_t;
		logic [TIME_W-1:0] wait_t;
		logic [TIME_W-1:0] tat;
		logic              ovf;
		logic              fin;
	} run_rec_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [VAL_W-1:0]  arrival_time = '0;
	logic [VAL_W-1:0]  burst_length = '0;
	logic              last_in = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [IDX_W-1:0]  job_index;
	logic [TIME_W-1:0] start_time;
	logic [TIME_W-1:0] wait_time;
	logic [TIME_W-1:0] turnaround_time;
	logic              overflowed;
	logic              last_out;

	job_word_t        job_feed[$];
	run_rec_t         run_order[$];
	run_rec_t         want;
	logic [VAL_W-1:0] held_arrival[JOB_SLOTS];
	logic [VAL_W-1:0] held_burst[JOB_SLOTS];
	bit               ran_mark[JOB_SLOTS];
	int               held_count = 0;
	logic             held_drop = 1'b0;
	int               errors = 0;
	int               idle_gap = 0;
	int               stall_left = 0;
	int               quiet_cycles = 0;
	logic             calm = 1'b0;
	logic             gappy = 1'b1;

	sjf_nonpreemptive_scheduler dut (.*);

	always #6 clk = ~clk;

	function automatic longint clip_time(input longint t);
		return (t > TIME_MAX) ? longint'(TIME_MAX) : t;
	endfunction

	function automatic int pick_shortest(input longint now);
		int pick;
		pick = -1;
		for (int i = 0; i < held_count; i++) begin
			if (ran_mark[i] || held_arrival[i] > now)
				continue;
			if (pick < 0 || held_burst[i] < held_burst[pick] ||
			    (held_burst[i] == held_burst[pick] && held_arrival[i] < held_arrival[pick]))
				pick = i;
		end
		return pick;
	endfunction

	// store one job; on the closing word, predict the whole run order
	task automatic take_job(input job_word_t w);
		longint   now;
		longint   earliest;
		longint   waited;
		longint   tat_l;
		int       pick;
		run_rec_t r;
		if (held_count < JOB_SLOTS) begin
			held_arrival[held_count] = w.arrival;
			held_burst[held_count] = w.burst;
			held_count++;
		end else begin
			held_drop = 1'b1;
		end
		if (!w.fin)
			return;
		now = 0;
		for (int k = 0; k < held_count; k++) begin
			pick = pick_shortest(now);
			if (pick < 0) begin
				earliest = 70000;
				for (int i = 0; i < held_count; i++)
					if (!ran_mark[i] && held_arrival[i] < earliest)
						earliest = held_arrival[i];
				now = earliest;
				pick = pick_shortest(now);
			end
			waited = now - held_arrival[pick];
			tat_l = clip_time(waited + held_burst[pick]);
			r.idx = pick[IDX_W-1:0];
			r.start_t = now[TIME_W-1:0];
			r.wait_t = waited[TIME_W-1:0];
			r.tat = tat_l[TIME_W-1:0];
			r.ovf = held_drop;
			r.fin = (k == held_count - 1);
			now = clip_time(now + held_burst[pick]);
			ran_mark[pick] = 1'b1;
			run_order.push_back(r);
		end
		ran_mark = '{default: 1'b0};
		held_count = 0;
		held_drop = 1'b0;
	endtask

	task automatic queue_job(input int a, input int b, input bit fin, input bit hold);
		job_feed.push_back(job_word_t'{a[VAL_W-1:0], b[VAL_W-1:0], fin, hold});
	endtask

	task automatic queue_random_set(input int n, input bit hold);
		int mode;
		int base;
		int a;
		int b;
		mode = $urandom_range(0, 3);
		base = 0;
		for (int j = 0; j < n; j++) begin
			case (mode)
				0: begin
					a = $urandom_range(0, 40);
					b = $urandom_range(0, 6);
				end
				1: begin
					a = $urandom_range(0, 65535);
					b = $urandom_range(0, 65535);
				end
				2: begin
					base += $urandom_range(0, 300);
					a = (base > 65535) ? 65535 : base;
					b = $urandom_range(0, 200);
				end
				default: begin
					a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
						$urandom_range(0, 500);
					b = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) :
						$urandom_range(0, 65535);
				end
			endcase
			queue_job(a, b, j == n - 1, hold && j == 0);
		end
	endtask

	initial begin
		int set_no;
		int n;
		queue_job(0, 0, 1'b1, 1'b0);
		queue_job(65535, 65535, 1'b1, 1'b1);
		// burst tie, then arrival tie, then load order
		queue_job(10, 7, 1'b0, 1'b0);
		queue_job(3, 7, 1'b0, 1'b0);
		queue_job(3, 7, 1'b0, 1'b0);
		queue_job(0, 9, 1'b0, 1'b0);
		queue_job(2, 1, 1'b1, 1'b0);
		// idle jumps and a zero-length job
		queue_job(100, 5, 1'b0, 1'b0);
		queue_job(0, 2, 1'b0, 1'b0);
		queue_job(50, 0, 1'b1, 1'b0);
		queue_job(65535, 0, 1'b0, 1'b0);
		queue_job(0, 65535, 1'b0, 1'b0);
		queue_job(21845, 43690, 1'b1, 1'b0);
		set_no = 0;
		while (job_feed.size() < FEED_TARGET) begin
			if (set_no == 2)
				n = JOB_SLOTS;
			else if (set_no == 5)
				n = JOB_SLOTS + 2;
			else if ($urandom_range(0, 9) == 0)
				n = $urandom_range(28, 36);
			else
				n = $urandom_range(1, 8);
			queue_random_set(n, set_no == 1 || $urandom_range(0, 5) == 0);
			set_no++;
		end
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (job_feed.size() != 0 || in_valid)
			@(posedge clk);
		while (run_order.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			gappy <= !gappy;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			arrival_time <= '0;
			burst_length <= '0;
			last_in <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				take_job(job_word_t'{arrival_time, burst_length, last_in, 1'b0});
			calm <= (job_feed.size() <= CALM_TAIL);
			if (!in_valid || in_ready) begin
				if (idle_gap > 0) begin
					idle_gap--;
					in_valid <= 1'b0;
				end else if (job_feed.size() == 0 ||
				             (job_feed[0].hold && run_order.size() != 0)) begin
					in_valid <= 1'b0;
				end else if (gappy && !calm && $urandom_range(0, 5) == 0) begin
					idle_gap = $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else begin
					arrival_time <= job_feed[0].arrival;
					burst_length <= job_feed[0].burst;
					last_in <= job_feed[0].fin;
					in_valid <= 1'b1;
					void'(job_feed.pop_front());
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (run_order.size() == 0) begin
					$error("result word with nothing expected, job_index %0d", job_index);
					errors++;
				end else begin
					want = run_order.pop_front();
					if (job_index !== want.idx) begin
						$error("job_index: expected %0d, got %0d", want.idx, job_index);
						errors++;
					end
					if (start_time !== want.start_t) begin
						$error("start_time: expected %0d, got %0d", want.start_t, start_time);
						errors++;
					end
					if (wait_time !== want.wait_t) begin
						$error("wait_time: expected %0d, got %0d", want.wait_t, wait_time);
						errors++;
					end
					if (turnaround_time !== want.tat) begin
						$error("turnaround_time: expected %0d, got %0d", want.tat,
							turnaround_time);
						errors++;
					end
					if (overflowed !== want.ovf) begin
						$error("overflowed: expected %0d, got %0d", want.ovf, overflowed);
						errors++;
					end
					if (last_out !== want.fin) begin
						$error("last_out: expected %0d, got %0d", want.fin, last_out);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (gappy && !calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
